// ===== rtl/core/tbpc_pkg.sv =====
`default_nettype none

package tbpc_pkg;

   localparam int unsigned ModeW           = 2;
   localparam int unsigned TargetW         = 8;
   localparam int unsigned PctW            = 7;
   localparam int unsigned DelayW          = 8;
   localparam int unsigned DurW            = 16;
   localparam int unsigned CsrIdxW         = 2;
   localparam int unsigned CsrDataW        = 16;
   localparam int unsigned ProdW           = 24;
   localparam int unsigned DivBitsPerCycle = 2;
   localparam int unsigned DivCycles       = ProdW / DivBitsPerCycle;
   localparam int unsigned CntW            = $clog2(DivCycles);

   localparam logic [PctW-1:0]   FullPercent = PctW'(100);
   localparam logic [DurW-1:0]   SatTicks    = {DurW{1'b1}};
   localparam logic [DurW-1:0]   DurReset    = DurW'(1000);
   localparam logic [DelayW-1:0] DelayReset  = '0;

   typedef enum logic [ModeW-1:0] {
      MODE_TICK = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_STOP = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_UP       = 2'd1,
      PH_DOWN     = 2'd2,
      PH_STOPPING = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      DRV_OFF  = 2'd0,
      DRV_UP   = 2'd1,
      DRV_DOWN = 2'd2
   } drive_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_REACTION_DELAY = 2'd0,
      CSR_OPEN_DURATION  = 2'd1,
      CSR_CLOSE_DURATION = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_MUL,
      ST_DIV,
      ST_COMMIT
   } ctrl_state_type;

   typedef struct packed {
      logic latch;
      logic mul;
      logic div_step;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic need_div;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/core/tbpc_if.sv =====
`default_nettype none

interface tbpc_req_if import tbpc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ModeW-1:0]   mode;
   logic [TargetW-1:0] target_position;
   logic               motor_running;

   modport source (output valid, mode, target_position, motor_running, input ready);
   modport sink   (input valid, mode, target_position, motor_running, output ready);
endinterface

interface tbpc_rsp_if import tbpc_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [1:0]      motor_drive;
   logic [PctW-1:0] position_now;
   logic [PctW-1:0] position_goal;
   logic [1:0]      control_phase;
   logic            report_pulse;

   modport source (output valid, motor_drive, position_now, position_goal, control_phase,
                   report_pulse, input ready);
   modport sink   (input valid, motor_drive, position_now, position_goal, control_phase,
                   report_pulse, output ready);
endinterface

interface tbpc_csr_if import tbpc_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [CsrIdxW-1:0]  index;
   logic [CsrDataW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/timed_blind_position_controller_unit.sv =====
// Open-loop blind positioner.
// req_bus carries one beat per event: a time tick, a move to a target percent
// (clamped to 100) or a stop command, plus the motor-running flag.
// rsp_bus returns exactly one beat per request: motor drive, estimated position,
// setpoint, control phase and a report flag set on the return to idle.
// csr_bus writes reaction delay (index 0), open duration (1) and close duration (2);
// csr_bus.ready is always high. Write it only while the block is idle.
// Flow: a request is accepted in idle and decoded; a tick, or a move/stop that
// needs no estimate, goes straight to commit, while a move start or a move or
// stop during a move first passes a multiply step and a 2-bit-per-cycle divider.
// One request is processed at a time; req_bus.ready rises again the cycle after
// the response is loaded, so the next request waits until this one is committed.
// The response sits in an output register: a new request is taken while it waits,
// and when rsp_bus.ready is low the next response holds in commit until it drains.
// Reset (synchronous, active high) sets idle, positions 0, timers 0, motor off,
// reaction delay 0 and both durations 1000.
`default_nettype none

module timed_blind_position_controller_unit import tbpc_pkg::*; (
   input  wire logic  clock,
   input  wire logic  reset,
   tbpc_req_if.sink   req_bus,
   tbpc_rsp_if.source rsp_bus,
   tbpc_csr_if.sink   csr_bus
);

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   tbpc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tbpc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_mode    (req_bus.mode),
      .req_target  (req_bus.target_position),
      .req_running (req_bus.motor_running),
      .rsp_bus     (rsp_bus),
      .csr_bus     (csr_bus)
   );

endmodule

`default_nettype wire

// ===== rtl/core/tbpc_ctrl.sv =====
`default_nettype none

module tbpc_ctrl import tbpc_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   ctrl_state_type  state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            div_last;

   assign div_last = (cnt_ff == CntW'(DivCycles - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECODE;
         end
         ST_DECODE: begin
            state_in = status.need_div ? ST_MUL : ST_COMMIT;
         end
         ST_MUL: begin
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_last) state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == ST_IDLE);
      cmd.latch    = (state_ff == ST_IDLE) && req_valid;
      cmd.mul      = (state_ff == ST_MUL);
      cmd.div_step = (state_ff == ST_DIV);
      cmd.commit   = (state_ff == ST_COMMIT) && status.out_free;
      cnt_in       = (state_ff == ST_DIV) ? cnt_ff + CntW'(1) : '0;
   end

   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) && div_last |=> (state_ff == ST_COMMIT))
      else $error("divider did not hand over to commit");

   a_mul_from_decode: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECODE) && status.need_div |=> (state_ff == ST_MUL))
      else $error("division request skipped multiply");

   a_idle_cnt_clear: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (cnt_ff == '0))
      else $error("step counter not cleared while idle");

endmodule

`default_nettype wire

// ===== rtl/core/tbpc_dp.sv =====
`default_nettype none

module tbpc_dp import tbpc_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire dp_cmd_type         cmd,
   output dp_status_type           status,
   input  wire logic [ModeW-1:0]   req_mode,
   input  wire logic [TargetW-1:0] req_target,
   input  wire logic               req_running,
   tbpc_rsp_if.source              rsp_bus,
   tbpc_csr_if.sink                csr_bus
);

   logic [DelayW-1:0] delay_ff;
   logic [DurW-1:0]   open_ff, close_ff;

   mode_type        mode_ff;
   logic [PctW-1:0] target_ff;
   logic            running_ff;

   phase_type       phase_ff, phase_in;
   drive_type       drive_ff, drive_in;
   logic [PctW-1:0] cur_ff, cur_in;
   logic [PctW-1:0] set_ff, set_in;
   logic [DurW-1:0] run_ff, run_in;
   logic [DurW-1:0] te_ff, te_in;
   logic            report_in;

   logic [ProdW-1:0] quo_ff, quo_in;
   logic [DurW-1:0]  rem_ff, rem_in;
   logic [DurW-1:0]  dvs_ff;

   logic            rsp_valid_ff;
   logic [1:0]      rsp_drive_ff;
   logic [PctW-1:0] rsp_now_ff, rsp_goal_ff;
   logic [1:0]      rsp_phase_ff;
   logic            rsp_report_ff;

   logic             moving, move_start, stop_est, go_down, est_up;
   logic [PctW-1:0]  diff;
   logic [DurW-1:0]  move_dur, est_dur, elapsed, te_inc, mul_a, divisor;
   logic [PctW-1:0]  mul_b;
   logic [ProdW-1:0] product, run_base, moved;
   logic [ProdW:0]   run_sum, up_sum;
   logic [DurW-1:0]  run_sat;
   logic [PctW-1:0]  est_pos;

   // configuration
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff <= DelayReset;
         open_ff  <= DurReset;
         close_ff <= DurReset;
      end else if (csr_bus.valid) begin
         unique case (csr_index_type'(csr_bus.index))
            CSR_REACTION_DELAY: delay_ff <= csr_bus.data[DelayW-1:0];
            CSR_OPEN_DURATION:  open_ff  <= csr_bus.data[DurW-1:0];
            CSR_CLOSE_DURATION: close_ff <= csr_bus.data[DurW-1:0];
            default: ;
         endcase
      end
   end

   // input beat capture, target clamped to full travel
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff    <= mode_type'(req_mode);
         target_ff  <= (req_target > TargetW'(FullPercent)) ? FullPercent
                                                            : req_target[PctW-1:0];
         running_ff <= req_running;
      end
   end

   always_comb begin
      moving     = (phase_ff == PH_UP) || (phase_ff == PH_DOWN);
      move_start = (mode_ff == MODE_MOVE) && (phase_ff == PH_IDLE) && (target_ff != cur_ff);
      stop_est   = ((mode_ff == MODE_MOVE) || (mode_ff == MODE_STOP)) && moving;
      go_down    = (target_ff < cur_ff);
      diff       = go_down ? cur_ff - target_ff : target_ff - cur_ff;
      move_dur   = go_down ? close_ff : open_ff;
      est_up     = (set_ff > cur_ff);
      est_dur    = est_up ? open_ff : close_ff;
      elapsed    = (te_ff > DurW'(delay_ff)) ? te_ff - DurW'(delay_ff) : '0;
      mul_a      = move_start ? move_dur : elapsed;
      mul_b      = move_start ? diff : FullPercent;
      divisor    = move_start ? DurW'(FullPercent) : est_dur;
      product    = ProdW'(mul_a) * ProdW'(mul_b);
   end

   assign status.need_div = move_start || stop_est;
   assign status.out_free = !rsp_valid_ff || rsp_bus.ready;

   // shared restoring divider, two quotient bits per cycle
   always_comb begin
      logic [DurW:0] r;
      r      = '0;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < DivBitsPerCycle; i++) begin
         r      = {rem_in, quo_in[ProdW-1]};
         quo_in = {quo_in[ProdW-2:0], 1'b0};
         if (r >= {1'b0, dvs_ff}) begin
            r         = r - {1'b0, dvs_ff};
            quo_in[0] = 1'b1;
         end
         rem_in = r[DurW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.mul) begin
         quo_ff <= product;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (cmd.div_step) begin
         quo_ff <= quo_in;
         rem_ff <= rem_in;
      end
   end

   always_comb begin
      if (go_down) begin
         run_base = (target_ff == '0) ? ProdW'(close_ff) : quo_ff;
      end else begin
         run_base = (target_ff == FullPercent) ? ProdW'(open_ff) : quo_ff;
      end
      run_sum = {1'b0, run_base} + (ProdW + 1)'(delay_ff);
      run_sat = (run_sum > (ProdW + 1)'(SatTicks)) ? SatTicks : run_sum[DurW-1:0];

      moved  = (est_dur == '0) ? ProdW'(FullPercent) : quo_ff;
      up_sum = {1'b0, moved} + (ProdW + 1)'(cur_ff);
      if (est_up) begin
         est_pos = (up_sum > (ProdW + 1)'(FullPercent)) ? FullPercent : up_sum[PctW-1:0];
      end else begin
         est_pos = (moved > ProdW'(cur_ff)) ? '0 : cur_ff - moved[PctW-1:0];
      end

      te_inc = (te_ff == SatTicks) ? te_ff : te_ff + DurW'(1);
   end

   always_comb begin
      phase_in  = phase_ff;
      drive_in  = drive_ff;
      cur_in    = cur_ff;
      set_in    = set_ff;
      run_in    = run_ff;
      te_in     = te_ff;
      report_in = 1'b0;
      unique case (mode_ff)
         MODE_TICK: begin
            te_in = te_inc;
            if (moving) begin
               if (te_inc >= run_ff) begin
                  drive_in = DRV_OFF;
                  cur_in   = set_ff;
                  phase_in = PH_STOPPING;
               end
            end else if ((phase_ff == PH_STOPPING) && !running_ff) begin
               phase_in  = PH_IDLE;
               report_in = 1'b1;
            end
         end
         MODE_MOVE, MODE_STOP: begin
            if (move_start) begin
               set_in   = target_ff;
               te_in    = '0;
               run_in   = run_sat;
               drive_in = go_down ? DRV_DOWN : DRV_UP;
               phase_in = go_down ? PH_DOWN : PH_UP;
            end else if ((mode_ff == MODE_STOP) || (phase_ff != PH_STOPPING)) begin
               drive_in = DRV_OFF;
               if (moving) begin
                  phase_in = PH_STOPPING;
                  cur_in   = est_pos;
                  set_in   = est_pos;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         drive_ff <= DRV_OFF;
         cur_ff   <= '0;
         set_ff   <= '0;
         run_ff   <= '0;
         te_ff    <= '0;
      end else if (cmd.commit) begin
         phase_ff <= phase_in;
         drive_ff <= drive_in;
         cur_ff   <= cur_in;
         set_ff   <= set_in;
         run_ff   <= run_in;
         te_ff    <= te_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_drive_ff  <= drive_in;
         rsp_now_ff    <= cur_in;
         rsp_goal_ff   <= set_in;
         rsp_phase_ff  <= phase_in;
         rsp_report_ff <= report_in;
      end
   end

   assign rsp_bus.valid         = rsp_valid_ff;
   assign rsp_bus.motor_drive   = rsp_drive_ff;
   assign rsp_bus.position_now  = rsp_now_ff;
   assign rsp_bus.position_goal = rsp_goal_ff;
   assign rsp_bus.control_phase = rsp_phase_ff;
   assign rsp_bus.report_pulse  = rsp_report_ff;

   a_drive_matches_phase: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_UP) == (drive_ff == DRV_UP)) &&
      ((phase_ff == PH_DOWN) == (drive_ff == DRV_DOWN)))
      else $error("motor drive disagrees with phase");

   a_position_range: assert property (@(posedge clock) disable iff (reset)
      (cur_ff <= FullPercent) && (set_ff <= FullPercent))
      else $error("position out of range");

   a_report_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && report_in |=> rsp_valid_ff && (rsp_phase_ff == PH_IDLE)
      && (phase_ff == PH_IDLE))
      else $error("report beat without return to idle");

endmodule

`default_nettype wire
